// ----- hdl/kbsh_pkg.sv -----
// Shared request/response types and codes for the keyboard strobe handshake block.
package kbsh_pkg;

   // Request modes
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_STEP  = 2'd1;
   localparam logic [1:0] MODE_ACK   = 2'd2;
   localparam logic [1:0] MODE_RESET = 2'd3;

   // Handshake phases
   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_WAIT_ACK   = 2'd1;
   localparam logic [1:0] PH_WAIT_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic CSR_ACK_TIMEOUT   = 1'b0;
   localparam logic CSR_CLEAR_TIMEOUT = 1'b1;

   localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd100;
   localparam logic [15:0] CLEAR_TIMEOUT_RESET = 16'd200;

   // Character filter constants
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  char_in;
      logic [31:0] now_ms;
      logic        clear_level;
   } req_type;

   typedef struct packed {
      logic       strobe_res;
      logic [7:0] data_out;
      logic [1:0] phase;
      logic       fifo_full;
      logic       fifo_empty;
      logic       idle;
      logic       push_dropped;
      logic       timed_out;
   } rsp_type;

endpackage

// ----- hdl/keyboard_strobe_handshake_top.sv -----
// Keyboard strobe handshake: character queue plus strobe/acknowledge/clear sequencer.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_data (mode, char_in, now_ms, clear_level)
//   rsp_     out        rsp_valid/rsp_stall  rsp_data (strobe, port byte, phase, flags)
//   csr_     in         csr_wr_en            csr_index, csr_wr_data (16 bit timeouts)
//
// One request per cycle while req_stall is low; its response is registered on acceptance.
// The character queue sits in a RAM whose read port always points at the next head,
// so a pop has its byte ready; a push into the entry being read is forwarded.
// A two-entry response buffer parts the sides: req_stall rises only when both
// entries hold unread responses. Reset is synchronous and takes effect at once,
// with no clearing pass; queue entries are only read after being written.
module keyboard_strobe_handshake_top
   import kbsh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   // Configuration
   logic [15:0] ack_to_ff, clear_to_ff;

   // Handshake state
   logic [1:0]    phase_ff, phase_in;
   logic          ack_ff, ack_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    port_ff, port_in;
   logic [31:0]   start_ff, start_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // Head forwarding for a push that lands on the entry being read
   logic          byp_ff;
   logic [6:0]    byp_data_ff;

   // Queue RAM
   logic          ram_wr_en;
   logic [6:0]    ram_wr_data;
   logic [6:0]    ram_rd_data;
   logic [6:0]    head_data;

   // Response buffer
   rsp_type       slot0_ff, slot1_ff;
   logic [1:0]    rsp_cnt_ff;
   rsp_type       rsp_new;

   logic          req_fire, rsp_fire;
   logic [31:0]   elapsed;
   logic          ack_late, clear_late;

   assign req_stall = (rsp_cnt_ff == 2'd2);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (rsp_cnt_ff != 2'd0);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign rsp_data  = slot0_ff;

   assign head_data  = byp_ff ? byp_data_ff : ram_rd_data;
   assign elapsed    = req_data.now_ms - start_ff;
   assign ack_late   = elapsed > {16'd0, ack_to_ff};
   assign clear_late = elapsed > {16'd0, clear_to_ff};

   kbsh_ram #(
      .WIDTH (7),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // Next state for the accepted request, and its response
   always_comb begin
      logic [7:0] ch;
      logic       dropped;
      logic       tout;
      logic       check_clear;

      ch          = req_data.char_in;
      dropped     = 1'b0;
      tout        = 1'b0;
      check_clear = 1'b0;

      phase_in    = phase_ff;
      ack_in      = ack_ff;
      strobe_in   = strobe_ff;
      port_in     = port_ff;
      start_in    = start_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      ram_wr_en   = 1'b0;

      // Filter the character: map LF to CR, fold lower case to upper case
      if (ch == CHAR_LF) begin
         ch = CHAR_CR;
      end
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         ch = ch - CASE_OFFSET;
      end
      ram_wr_data = ch[6:0];

      if (req_fire) begin
         case (req_data.mode)
            MODE_PUSH: begin
               if (req_data.char_in[7] || count_ff == FULL_CNT) begin
                  dropped = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            MODE_STEP: begin
               case (phase_ff)
                  PH_WAIT_ACK: begin
                     if (!ack_ff) begin
                        if (ack_late) begin
                           tout = 1'b1;
                        end
                     end else begin
                        strobe_in   = 1'b0;
                        ack_in      = 1'b0;
                        phase_in    = PH_WAIT_CLEAR;
                        check_clear = 1'b1;
                     end
                  end
                  PH_WAIT_CLEAR: begin
                     check_clear = 1'b1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (count_ff != '0) begin
                        port_in   = {1'b1, head_data};
                        head_in   = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                        ack_in    = 1'b0;
                        strobe_in = 1'b1;
                        start_in  = req_data.now_ms;
                        phase_in  = PH_WAIT_ACK;
                     end
                  end
               endcase
               if (check_clear) begin
                  if (!req_data.clear_level) begin
                     phase_in = PH_IDLE;
                  end else if (clear_late) begin
                     tout = 1'b1;
                  end
               end
               // Abort on timeout: drop strobe, zero the port
               if (tout) begin
                  strobe_in = 1'b0;
                  port_in   = 8'd0;
                  ack_in    = 1'b0;
                  phase_in  = PH_IDLE;
               end
            end
            MODE_ACK: begin
               ack_in = 1'b1;
            end
            default: begin
               strobe_in = 1'b0;
               port_in   = 8'd0;
               ack_in    = 1'b0;
               start_in  = 32'd0;
               phase_in  = PH_IDLE;
            end
         endcase
      end

      rsp_new.strobe_res   = strobe_in;
      rsp_new.data_out     = port_in;
      rsp_new.phase        = phase_in;
      rsp_new.fifo_full    = (count_in == FULL_CNT);
      rsp_new.fifo_empty   = (count_in == '0);
      rsp_new.idle         = (count_in == '0) && (phase_in == PH_IDLE);
      rsp_new.push_dropped = dropped;
      rsp_new.timed_out    = tout;
   end

   // Handshake and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ack_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         port_ff   <= 8'd0;
         start_ff  <= 32'd0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         byp_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ack_ff    <= ack_in;
         strobe_ff <= strobe_in;
         port_ff   <= port_in;
         start_ff  <= start_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         // Forward a write that hits the entry the RAM is reading this cycle
         byp_ff    <= ram_wr_en && (tail_ff == head_in);
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= ram_wr_data;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_to_ff   <= ACK_TIMEOUT_RESET;
         clear_to_ff <= CLEAR_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ACK_TIMEOUT:   ack_to_ff   <= csr_wr_data;
            CSR_CLEAR_TIMEOUT: clear_to_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Two-entry response buffer: slot0 is shown, slot1 holds the skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_cnt_ff <= 2'd0;
      end else begin
         rsp_cnt_ff <= rsp_cnt_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire && rsp_cnt_ff == 2'd2) begin
         slot0_ff <= slot1_ff;
      end
      if (req_fire) begin
         if (rsp_cnt_ff == 2'd0 || (rsp_cnt_ff == 2'd1 && rsp_fire)) begin
            slot0_ff <= rsp_new;
         end else begin
            slot1_ff <= rsp_new;
         end
      end
   end

   // Strobe is only high while waiting for acknowledge
   a_strobe_phase: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> phase_ff == PH_WAIT_ACK)
      else $error("strobe high outside acknowledge wait");

   // Queue fill never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   // Response buffer never overfills
   a_rsp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_cnt_ff != 2'd3)
      else $error("response buffer overflow");

   // A pop from idle raises the strobe with bit 7 of the port set
   a_pop_drive: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == MODE_STEP && phase_ff == PH_IDLE && count_ff != '0)
      |=> strobe_ff && port_ff[7] && count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not drive the port");

   // Forwarding is only armed when the queue was empty before the push
   a_bypass_empty: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> count_ff == CW'(1) || $past(req_data.mode) == MODE_PUSH)
      else $error("forwarding armed with a non-empty queue");

endmodule

// ----- hdl/kbsh_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module kbsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- bench/keyboard_strobe_handshake_top_tb.sv -----
// Self-checking testbench for the keyboard strobe handshake block: random and directed requests.
import kbsh_pkg::*;

// Scoreboard: tracks the queue and strobe sequencer state and holds the responses it predicts.
class kbd_port_scoreboard #(parameter int DEPTH = 16);
   logic [1:0]  phase_now;
   bit          ack_seen;
   bit          strobe_now;
   logic [7:0]  port_byte;
   logic [31:0] start_ms;
   logic [6:0]  char_fifo [DEPTH];
   int unsigned rd_ptr, wr_ptr, fill;
   logic [15:0] ack_limit, clear_limit;

   rsp_type     pending_port_rsp [$];
   int unsigned requests, checked, failures, strobes, timeouts, drops;

   function new();
      phase_now   = PH_IDLE;
      ack_seen    = 1'b0;
      strobe_now  = 1'b0;
      port_byte   = 8'h00;
      start_ms    = '0;
      rd_ptr      = 0;
      wr_ptr      = 0;
      fill        = 0;
      ack_limit   = ACK_TIMEOUT_RESET;
      clear_limit = CLEAR_TIMEOUT_RESET;
   endfunction

   function void write_register(logic index, logic [15:0] value);
      if (index == CSR_ACK_TIMEOUT)
         ack_limit = value;
      else
         clear_limit = value;
   endfunction

   function int unsigned pending();
      return pending_port_rsp.size();
   endfunction

   function void drop_transfer();
      strobe_now = 1'b0;
      port_byte  = 8'h00;
      ack_seen   = 1'b0;
      phase_now  = PH_IDLE;
   endfunction

   // Advance the sequencer by one step; return 1 when the step ends it by timeout.
   function bit step_handshake(logic [31:0] now, logic clear_level);
      logic [31:0] held;
      held = now - start_ms;
      if (phase_now == PH_WAIT_ACK) begin
         if (!ack_seen) begin
            if (held > 32'(ack_limit)) begin
               drop_transfer();
               return 1'b1;
            end
            return 1'b0;
         end
         // acknowledged: drop the strobe and fall through to the clear check
         strobe_now = 1'b0;
         ack_seen   = 1'b0;
         phase_now  = PH_WAIT_CLEAR;
      end
      if (phase_now == PH_WAIT_CLEAR) begin
         if (!clear_level) begin
            phase_now = PH_IDLE;
            return 1'b0;
         end
         if (held > 32'(clear_limit)) begin
            drop_transfer();
            return 1'b1;
         end
         return 1'b0;
      end
      phase_now = PH_IDLE;
      if (fill == 0)
         return 1'b0;
      port_byte  = {1'b1, char_fifo[rd_ptr]};
      rd_ptr     = (rd_ptr + 1) % DEPTH;
      fill--;
      ack_seen   = 1'b0;
      strobe_now = 1'b1;
      start_ms   = now;
      phase_now  = PH_WAIT_ACK;
      strobes++;
      return 1'b0;
   endfunction

   function void note_request(req_type r);
      rsp_type    want;
      logic [7:0] c;
      want = '0;
      requests++;
      case (r.mode)
         MODE_PUSH: begin
            c = r.char_in;
            if (c[7]) begin
               want.push_dropped = 1'b1;
            end else begin
               if (c == CHAR_LF)
                  c = CHAR_CR;
               if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                  c = c - CASE_OFFSET;
               if (fill >= DEPTH) begin
                  want.push_dropped = 1'b1;
               end else begin
                  char_fifo[wr_ptr] = c[6:0];
                  wr_ptr = (wr_ptr + 1) % DEPTH;
                  fill++;
               end
            end
            if (want.push_dropped)
               drops++;
         end
         MODE_STEP: begin
            want.timed_out = step_handshake(r.now_ms, r.clear_level);
            if (want.timed_out)
               timeouts++;
         end
         MODE_ACK:
            ack_seen = 1'b1;
         default: begin
            drop_transfer();
            start_ms = '0;
         end
      endcase
      want.strobe_res = strobe_now;
      want.data_out   = port_byte;
      want.phase      = phase_now;
      want.fifo_full  = (fill >= DEPTH);
      want.fifo_empty = (fill == 0);
      want.idle       = (fill == 0) && (phase_now == PH_IDLE);
      pending_port_rsp.push_back(want);
   endfunction

   function void note_failure(string msg);
      failures++;
      if (failures <= 10)
         $display("mismatch: %s", msg);
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (pending_port_rsp.size() == 0) begin
         note_failure($sformatf("response %h with none outstanding", got));
         return;
      end
      want = pending_port_rsp.pop_front();
      if (got.strobe_res !== want.strobe_res || got.data_out !== want.data_out ||
          got.phase !== want.phase || got.fifo_full !== want.fifo_full ||
          got.fifo_empty !== want.fifo_empty || got.idle !== want.idle ||
          got.push_dropped !== want.push_dropped || got.timed_out !== want.timed_out)
         note_failure($sformatf({"response %0d: strobe/data/phase/full/empty/idle/drop/tout",
            " expected %b/%h/%0d/%b/%b/%b/%b/%b got %b/%h/%0d/%b/%b/%b/%b/%b"}, checked,
            want.strobe_res, want.data_out, want.phase, want.fifo_full, want.fifo_empty,
            want.idle, want.push_dropped, want.timed_out,
            got.strobe_res, got.data_out, got.phase, got.fifo_full, got.fifo_empty,
            got.idle, got.push_dropped, got.timed_out));
      checked++;
   endfunction
endclass

module keyboard_strobe_handshake_top_tb;

   localparam int QUEUE_DEPTH     = 16;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_REQUESTS  = 280;
   localparam int HOLD_OFF_CYCLES = 300;
   // Far beyond the slowest legal run.
   localparam int RUN_LIMIT_CYCLES = 400000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wr_data;

   kbd_port_scoreboard #(QUEUE_DEPTH) port_model;

   // Idle rates in percent, set per phase by the stimulus process.
   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 54;
   // Long receiver hold-offs: asked for by the stimulus, served by the receiver.
   int unsigned holds_asked  = 0;
   int unsigned holds_served = 0;

   keyboard_strobe_handshake_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Check every response taken at a clock edge against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         port_model.check_response(rsp_data);
   end

   // Receiver: stall at random, or hold off for a long stretch when asked.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            // hold the response side shut so the block fills and stalls requests
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Offer one request, idling each cycle at the sender rate, and wait until it is taken.
   // Leave valid high on return so back-to-back requests need no extra edge.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      port_model.note_request(r);
   endtask

   // Stop offering and wait for every predicted response, plus the buffer latency.
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (port_model.pending() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write both timeout registers, the ack timeout first, then the clear timeout; the block must be idle.
   task automatic write_timeouts(input logic [15:0] ack_ms, input logic [15:0] clear_ms);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ACK_TIMEOUT;
      csr_wr_data <= ack_ms;
      @(posedge clock);
      port_model.write_register(CSR_ACK_TIMEOUT, ack_ms);
      csr_index   <= CSR_CLEAR_TIMEOUT;
      csr_wr_data <= clear_ms;
      @(posedge clock);
      port_model.write_register(CSR_CLEAR_TIMEOUT, clear_ms);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic req_type push_req(input logic [7:0] c);
      req_type r;
      r = '0;
      r.mode    = MODE_PUSH;
      r.char_in = c;
      return r;
   endfunction

   function automatic req_type step_req(input logic [31:0] now, input logic clear_level);
      req_type r;
      r = '0;
      r.mode        = MODE_STEP;
      r.now_ms      = now;
      r.clear_level = clear_level;
      return r;
   endfunction

   function automatic req_type mode_req(input logic [1:0] mode);
      req_type r;
      r = '0;
      r.mode = mode;
      return r;
   endfunction

   // Random request: pushes at the given rate, acknowledges and resets now and then,
   // and steps whose times sit on and around the timeout edges of the current transfer.
   function automatic req_type random_request(input int unsigned push_pct);
      req_type     r;
      int unsigned pick;
      logic [31:0] delay;
      r.mode        = MODE_STEP;
      r.char_in     = 8'($urandom);
      r.now_ms      = $urandom;
      r.clear_level = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < push_pct) begin
         r.mode = MODE_PUSH;
         case ($urandom_range(5))
            0: r.char_in = CHAR_LOWER_A + 8'($urandom_range(25));
            1: r.char_in = CHAR_LF;
            2: r.char_in = 8'h80 | 8'($urandom_range(127));
            default: r.char_in = 8'($urandom_range(255));
         endcase
      end else if (pick < push_pct + 12) begin
         r.mode = MODE_ACK;
      end else if (pick < push_pct + 15) begin
         r.mode = MODE_RESET;
      end else begin
         case ($urandom_range(7))
            0: delay = 32'(port_model.ack_limit);
            1: delay = 32'(port_model.ack_limit) + 1;
            2: delay = 32'(port_model.clear_limit);
            3: delay = 32'(port_model.clear_limit) + 1;
            4: delay = $urandom_range(32'(port_model.ack_limit));
            5: delay = $urandom_range(32'(port_model.clear_limit));
            default: delay = 0;
         endcase
         case ($urandom_range(9))
            // start a transfer just below the wrap point now and then
            0: r.now_ms = ~32'($urandom_range(255));
            1: ;
            default: r.now_ms = port_model.start_ms + delay;
         endcase
      end
      return r;
   endfunction

   // Stimulus: reset, directed corner cases, then random phases over several settings.
   initial begin
      logic [31:0] t0;
      int unsigned push_pct;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_ACK_TIMEOUT;
      csr_wr_data = '0;
      port_model  = new();
      push_pct    = 30;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset timeouts; start times sit just below the wrap.
      t0 = 32'hFFFF_FFC0;
      send_request(step_req(t0, 1'b1));            // step with nothing queued
      send_request(push_req(CHAR_LOWER_A));        // lower case converts
      send_request(push_req(CHAR_LOWER_Z));
      send_request(push_req(CHAR_LF));             // line feed becomes carriage return
      send_request(push_req(8'h80));               // high bytes are filtered out
      send_request(push_req(8'hFF));
      send_request(push_req(8'h7F));
      send_request(push_req(8'h00));
      send_request(step_req(t0, 1'b1));            // pop and raise the strobe
      send_request(step_req(t0 + 100, 1'b1));      // exactly at the limit: still waiting
      send_request(step_req(t0 + 101, 1'b1));      // one past, across the wrap: timeout
      send_request(step_req(t0 + 5, 1'b1));
      send_request(mode_req(MODE_ACK));
      send_request(step_req(t0 + 10, 1'b1));       // acknowledged, clear still high
      send_request(step_req(t0 + 205, 1'b1));      // clear limit reached, not passed
      send_request(step_req(t0 + 206, 1'b1));      // clear timeout
      send_request(step_req(t0 + 300, 1'b1));
      send_request(mode_req(MODE_ACK));
      send_request(step_req(t0 + 301, 1'b0));      // clear low: back to idle, byte kept
      send_request(mode_req(MODE_ACK));            // acknowledge while idle
      send_request(step_req(t0 + 302, 1'b1));      // new strobe clears the stale flag
      send_request(mode_req(MODE_RESET));          // drop the transfer, keep the queue
      send_request(step_req(t0 + 400, 1'b1));
      send_request(mode_req(MODE_ACK));
      send_request(step_req(t0 + 601, 1'b1));      // ack and clear timeout in one step
      send_request(mode_req(MODE_RESET));
      // Fill the queue and push once more into it.
      repeat (QUEUE_DEPTH + 1)
         send_request(push_req(CHAR_LOWER_A + 8'($urandom_range(25))));
      drain_requests();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: write_timeouts(16'd0, 16'd0);
            1: write_timeouts(16'hFFFF, 16'hFFFF);
            2: write_timeouts(16'($urandom_range(300)), 16'($urandom_range(300)));
            3: write_timeouts(16'($urandom), 16'($urandom));
            4: write_timeouts(16'd0, 16'hFFFF);
            default: write_timeouts(16'hFFFF, 16'd0);
         endcase
         if (ph == 2) begin
            send_idle_pct = 54;
            recv_idle_pct = 9;
         end else if (ph == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // shut the response side for a while and keep sending
            holds_asked++;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 40 == 0)
               push_pct = $urandom_range(10, 60);
            send_request(random_request(push_pct));
         end
         drain_requests();
      end

      $display("covered %0d requests with %0d responses checked over six timeout settings",
         port_model.requests, port_model.checked);
      $display("  %0d bytes strobed, %0d handshake timeouts, %0d pushes dropped",
         port_model.strobes, port_model.timeouts, port_model.drops);
      if (port_model.failures == 0 && port_model.pending() == 0) begin
         $display("keyboard_strobe_handshake_top_tb: PASS");
      end else begin
         $display("keyboard_strobe_handshake_top_tb: FAIL");
      end
      $finish;
   end

   // Watchdog: end the run if it hangs.
   initial begin
      #(RUN_LIMIT_CYCLES * 4);
      $display("timeout with %0d responses outstanding", port_model.pending());
      $display("keyboard_strobe_handshake_top_tb: FAIL");
      $finish;
   end

endmodule
